/* src/cgrs_pkg.sv */
package cgrs_pkg;

   localparam int MAX_STOPS_DEF    = 8;
   localparam int SAMPLE_COUNT_DEF = 32;

   localparam int POS_W   = 17;
   localparam int COLOR_W = 16;
   localparam int CHAN_N  = 4;
   localparam int ENTRY_W = POS_W + CHAN_N * COLOR_W;

   localparam logic [POS_W-1:0] ONE_Q16 = POS_W'(65536);

   // Element 3 is red, then green, blue and alpha in element 0.
   typedef logic [CHAN_N-1:0][COLOR_W-1:0] color_type;

endpackage

/* src/cgrs_ram.sv */
module cgrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/color_gradient_ramp_sampler_core.sv */
// Piecewise-linear color ramp sampler. Gradient stops enter one per transfer, positions in
// unsigned Q16 (clamped to 1.0) and colors as 16-bit RGBA; stops past MAX_STOPS are dropped.
// A stop transfer that is not flagged last leaves the block ready. The stop flagged last
// makes the block sample the ramp at SAMPLE_COUNT evenly spaced points and send one result
// transfer per point, the final one flagged last_sample; the store is then empty. During
// sampling req_ready is low. Each point walks the stored stops through the single registered
// read port of the stop memory; a point between two stops then runs a restoring divider for
// the fraction, unless it is 1.0, and a shared 17x18 multiplier over four channels. The
// result register lets the next stops be taken while the final result still waits.
module color_gradient_ramp_sampler_core #(
   parameter int MAX_STOPS    = cgrs_pkg::MAX_STOPS_DEF,
   parameter int SAMPLE_COUNT = cgrs_pkg::SAMPLE_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [cgrs_pkg::POS_W-1:0]   req_stop_pos,
   input  logic [cgrs_pkg::COLOR_W-1:0] req_stop_red,
   input  logic [cgrs_pkg::COLOR_W-1:0] req_stop_green,
   input  logic [cgrs_pkg::COLOR_W-1:0] req_stop_blue,
   input  logic [cgrs_pkg::COLOR_W-1:0] req_stop_alpha,
   input  logic                         req_last_stop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cgrs_pkg::COLOR_W-1:0] rsp_out_red,
   output logic [cgrs_pkg::COLOR_W-1:0] rsp_out_green,
   output logic [cgrs_pkg::COLOR_W-1:0] rsp_out_blue,
   output logic [cgrs_pkg::COLOR_W-1:0] rsp_out_alpha,
   output logic                         rsp_last_sample
);

   import cgrs_pkg::*;

   localparam int IDXW   = $clog2(MAX_STOPS);
   localparam int CNTW   = $clog2(MAX_STOPS + 1);
   localparam int SW     = $clog2(SAMPLE_COUNT);
   localparam int Q_STEP = 65536 / SAMPLE_COUNT;
   localparam int R_STEP = 65536 % SAMPLE_COUNT;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_TEST  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_ADD   = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [CNTW-1:0]        held_ff, held_in;
   logic [CNTW-1:0]        count_ff, count_in;
   logic [IDXW-1:0]        idx_ff, idx_in;
   logic [SW-1:0]          samp_ff, samp_in;
   logic [POS_W-1:0]       t_ff, t_in;
   logic [SW-1:0]          rem_ff, rem_in;
   logic [POS_W-1:0]       prev_pos_ff, prev_pos_in;
   color_type              prev_color_ff, prev_color_in;
   color_type              next_color_ff, next_color_in;
   logic [POS_W-1:0]       div_rem_ff, div_rem_in;
   logic [POS_W-1:0]       div_den_ff, div_den_in;
   logic [POS_W-1:0]       frac_ff, frac_in;
   logic [3:0]             div_cnt_ff, div_cnt_in;
   logic [1:0]             chan_ff, chan_in;
   logic signed [34:0]     prod_ff, prod_in;
   color_type              res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   color_type              rsp_color_ff, rsp_color_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   wr_en;
   logic [ENTRY_W-1:0]     wr_data;
   logic [ENTRY_W-1:0]     rd_data;
   logic [POS_W-1:0]       pos_clamped;
   logic [POS_W-1:0]       rd_pos;
   color_type              rd_color;
   logic                   not_full;
   logic                   at_end;
   logic [POS_W-1:0]       span_x;
   logic [POS_W-1:0]       span_d;
   logic [POS_W-1:0]       div_shift;
   logic                   div_bit;
   logic signed [16:0]     chan_diff;
   logic signed [34:0]     blend_sum;
   logic                   is_last_samp;
   logic [SW:0]            rem_sum;

   assign pos_clamped = (req_stop_pos > ONE_Q16) ? ONE_Q16 : req_stop_pos;
   assign not_full    = held_ff < CNTW'(MAX_STOPS);
   assign req_ready   = state_ff == ST_IDLE;
   assign wr_en       = req_valid && req_ready && not_full;
   assign wr_data     = {pos_clamped, req_stop_red, req_stop_green, req_stop_blue,
                         req_stop_alpha};

   cgrs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_STOPS)
   ) u_stop_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (held_ff[IDXW-1:0]),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rd_pos       = rd_data[ENTRY_W-1 -: POS_W];
   assign rd_color     = color_type'(rd_data[CHAN_N*COLOR_W-1:0]);
   assign at_end       = CNTW'(idx_ff) == (count_ff - CNTW'(1));
   assign span_x       = t_ff - prev_pos_ff;
   assign span_d       = rd_pos - prev_pos_ff;
   assign div_shift    = {div_rem_ff[POS_W-2:0], 1'b0};
   assign div_bit      = div_shift >= div_den_ff;
   assign chan_diff    = $signed({1'b0, next_color_ff[chan_ff]}) -
                         $signed({1'b0, prev_color_ff[chan_ff]});
   assign blend_sum    = $signed({19'd0, prev_color_ff[chan_ff]}) + (prod_ff >>> 16);
   assign is_last_samp = samp_ff == SW'(SAMPLE_COUNT - 1);
   assign rem_sum      = {1'b0, rem_ff} + (SW + 1)'(R_STEP);

   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      samp_in       = samp_ff;
      t_in          = t_ff;
      rem_in        = rem_ff;
      prev_pos_in   = prev_pos_ff;
      prev_color_in = prev_color_ff;
      next_color_in = next_color_ff;
      div_rem_in    = div_rem_ff;
      div_den_in    = div_den_ff;
      frac_in       = frac_ff;
      div_cnt_in    = div_cnt_ff;
      chan_in       = chan_ff;
      prod_in       = prod_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_last_in   = rsp_last_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (not_full) begin
                  held_in = held_ff + CNTW'(1);
               end
               if (req_last_stop) begin
                  count_in = not_full ? held_ff + CNTW'(1) : held_ff;
                  held_in  = '0;
                  idx_in   = '0;
                  samp_in  = '0;
                  t_in     = '0;
                  rem_in   = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_TEST;
         end
         ST_TEST: begin
            priority if (t_ff <= rd_pos && idx_ff == '0) begin
               res_in   = rd_color;
               state_in = ST_EMIT;
            end else if (t_ff <= rd_pos) begin
               next_color_in = rd_color;
               chan_in       = '0;
               if (rd_pos <= prev_pos_ff || span_x == span_d) begin
                  frac_in  = ONE_Q16;
                  state_in = ST_MUL;
               end else begin
                  div_rem_in = span_x;
                  div_den_in = span_d;
                  frac_in    = '0;
                  div_cnt_in = '0;
                  state_in   = ST_DIV;
               end
            end else if (at_end) begin
               res_in   = rd_color;
               state_in = ST_EMIT;
            end else begin
               prev_pos_in   = rd_pos;
               prev_color_in = rd_color;
               idx_in        = idx_ff + IDXW'(1);
               state_in      = ST_FETCH;
            end
         end
         ST_DIV: begin
            div_rem_in = div_bit ? div_shift - div_den_ff : div_shift;
            frac_in    = {frac_ff[POS_W-2:0], div_bit};
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'd15) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = chan_diff * $signed({1'b0, frac_ff});
            state_in = ST_ADD;
         end
         ST_ADD: begin
            res_in[chan_ff] = blend_sum[COLOR_W-1:0];
            chan_in         = chan_ff + 2'd1;
            state_in        = (chan_ff == 2'd3) ? ST_EMIT : ST_MUL;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = res_ff;
               rsp_last_in  = is_last_samp;
               if (is_last_samp) begin
                  state_in = ST_IDLE;
               end else begin
                  samp_in  = samp_ff + SW'(1);
                  idx_in   = '0;
                  if (rem_sum >= (SW + 1)'(SAMPLE_COUNT)) begin
                     rem_in = SW'(rem_sum - (SW + 1)'(SAMPLE_COUNT));
                     t_in   = t_ff + POS_W'(Q_STEP + 1);
                  end else begin
                     rem_in = rem_sum[SW-1:0];
                     t_in   = t_ff + POS_W'(Q_STEP);
                  end
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff      <= count_in;
      idx_ff        <= idx_in;
      samp_ff       <= samp_in;
      t_ff          <= t_in;
      rem_ff        <= rem_in;
      prev_pos_ff   <= prev_pos_in;
      prev_color_ff <= prev_color_in;
      next_color_ff <= next_color_in;
      div_rem_ff    <= div_rem_in;
      div_den_ff    <= div_den_in;
      frac_ff       <= frac_in;
      div_cnt_ff    <= div_cnt_in;
      chan_ff       <= chan_in;
      prod_ff       <= prod_in;
      res_ff        <= res_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_red     = rsp_color_ff[3];
   assign rsp_out_green   = rsp_color_ff[2];
   assign rsp_out_blue    = rsp_color_ff[1];
   assign rsp_out_alpha   = rsp_color_ff[0];
   assign rsp_last_sample = rsp_last_ff;

endmodule

/* src/cgrs_checker.sv */
module cgrs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_last_stop,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [cgrs_pkg::COLOR_W-1:0] rsp_out_red,
   input logic [cgrs_pkg::COLOR_W-1:0] rsp_out_green,
   input logic [cgrs_pkg::COLOR_W-1:0] rsp_out_blue,
   input logic [cgrs_pkg::COLOR_W-1:0] rsp_out_alpha,
   input logic                         rsp_last_sample
);

   import cgrs_pkg::*;

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_red) &&
         $stable(rsp_out_green) && $stable(rsp_out_blue) && $stable(rsp_out_alpha) &&
         $stable(rsp_last_sample))
      else $error("stalled result changed");

   // The transfer of a last stop starts sampling, which blocks new stops.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_stop |=> !req_ready)
      else $error("block still ready after the last stop");

   // Stops other than the last one never make the block busy.
   assert property (@(posedge clock) disable iff (reset)
      req_ready && !(req_valid && req_last_stop) |=> req_ready)
      else $error("block went busy without a last stop");

   // A new result only appears while sampling is in progress.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while the block was idle");

endmodule

bind color_gradient_ramp_sampler_core cgrs_checker u_cgrs_checker (.*);
